>>> rtl/core/fmpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmpm_pkg
// Shared constants for the Fibonacci matrix power modulo core: sequencer
// states, operation codes and the serial multiplier step count.
// ----------------------------------------------------------------------------
package fmpm_pkg;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;

    // operations run on the shared mulmod unit
    localparam logic [2:0] OP_R1 = 3'd0;  // first seed mod m
    localparam logic [2:0] OP_R2 = 3'd1;  // second seed mod m
    localparam logic [2:0] OP_AA = 3'd2;  // a*a
    localparam logic [2:0] OP_BB = 3'd3;  // b*b
    localparam logic [2:0] OP_AB = 3'd4;  // a*b
    localparam logic [2:0] OP_F1 = 3'd5;  // s2*a
    localparam logic [2:0] OP_F2 = 3'd6;  // s1*b

    // multiplier operand width, one bit consumed per cycle
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = 5;

    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage : fmpm_pkg
`default_nettype wire

>>> rtl/core/fibonacci_matrix_power_mod_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fibonacci_matrix_power_mod_core
// Computes (second_seed*F(n+1) + first_seed*F(n)) mod modulus by square and
// multiply over the bits of n, on one shared bit-serial mulmod unit.
// ----------------------------------------------------------------------------
//
// channel   | signals                                  | transfer
// ----------+------------------------------------------+--------------------------
// command   | start, first_seed, second_seed, index    | start && !busy
// result    | done, value                              | done (one cycle)
// config    | psel, penable, pwrite, paddr, pwdata ... | psel&&penable&&pwrite
//
// Work: each modular product runs bit-serially in the Horner unit, between a
//   load and a store state. An item costs 2 seed reductions, 3 products and
//   one update state per index bit, and 2 final products.
//   A modulus below two returns 0 with the strobe in the cycle right after
//   the command transfer; busy stays low, so commands can follow every cycle.
// Reset: asynchronous, active low; modulus returns to 1000000007.
// Stalls: none; the result strobe cannot be held off by the receiver.
//
module fibonacci_matrix_power_mod_core
    import fmpm_pkg::*;
#(
    parameter int INDEX_BITS = 63,
    parameter int MOD_BITS   = 31
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    // command
    input  wire                   start,
    output logic                  busy,
    input  wire  [30:0]           first_seed,
    input  wire  [30:0]           second_seed,
    input  wire  [INDEX_BITS-1:0] index,
    // result
    output logic                  done,
    output logic [30:0]           value,
    // configuration
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [2:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // effective modulus width: register is kept to 31 bits at most
    localparam int MW    = (MOD_BITS < 31) ? MOD_BITS : 31;
    localparam int AW    = MW + 2;  // Horner accumulator width, holds a sum < 3m
    localparam int BCW   = $clog2(INDEX_BITS + 1);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [MW-1:0] modulus_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET[MW-1:0];
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            modulus_reg <= pwdata[MW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata[MW-1:0] = modulus_reg;
        end
    end

    // ------------------------------------------------------------------
    // modular helpers; operands already below m
    // ------------------------------------------------------------------
    function automatic logic [MW-1:0] addmod(input logic [MW-1:0] x,
                                             input logic [MW-1:0] y,
                                             input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MW-1:0];
    endfunction

    function automatic logic [MW-1:0] submod(input logic [MW-1:0] x,
                                             input logic [MW-1:0] y,
                                             input logic [MW-1:0] m);
        logic [MW:0] d;
        if (x >= y)
        begin
            d = {1'b0, x} - {1'b0, y};
        end
        else
        begin
            d = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return d[MW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [2:0]            state_reg;
    logic [2:0]            op_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [BCW-1:0]        bits_reg;
    logic [INDEX_BITS-1:0] n_reg;
    logic [30:0]           raw1_reg, raw2_reg;
    logic [MW-1:0]         s1_reg, s2_reg, a_reg, b_reg, aa_reg, bb_reg, f1_reg;
    logic [MUL_STEPS-1:0]  x_reg;
    logic [MW-1:0]         y_reg;
    logic [AW-1:0]         acc_reg;
    logic                  done_reg;
    logic [30:0]           value_reg;

    // one Horner step: acc = 2*acc + bit*y, reduced below m
    logic [AW-1:0] acc_sum, acc_step, m_ext;

    always_comb
    begin
        m_ext   = {2'b00, modulus_reg};
        acc_sum = {acc_reg[AW-2:0], 1'b0}
                + (x_reg[MUL_STEPS-1] ? {2'b00, y_reg} : '0);
        if (acc_sum >= {m_ext[AW-2:0], 1'b0})
        begin
            acc_step = acc_sum - {m_ext[AW-2:0], 1'b0};
        end
        else if (acc_sum >= m_ext)
        begin
            acc_step = acc_sum - m_ext;
        end
        else
        begin
            acc_step = acc_sum;
        end
    end

    logic [MW-1:0] prod;
    assign prod = acc_reg[MW-1:0];

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_R1;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        raw1_reg <= first_seed;
                        raw2_reg <= second_seed;
                        n_reg    <= index;
                        bits_reg <= BCW'(INDEX_BITS);
                        a_reg    <= MW'(1);
                        b_reg    <= '0;
                        op_reg   <= OP_R1;
                        if (modulus_reg < MW'(2))
                        begin
                            value_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end

                S_LOAD:
                begin
                    acc_reg <= '0;
                    cnt_reg <= CNT_W'(MUL_STEPS - 1);
                    case (op_reg)
                        OP_R1:   begin x_reg <= {1'b0, raw1_reg}; y_reg <= MW'(1); end
                        OP_R2:   begin x_reg <= {1'b0, raw2_reg}; y_reg <= MW'(1); end
                        OP_AA:   begin x_reg <= MUL_STEPS'(a_reg); y_reg <= a_reg; end
                        OP_BB:   begin x_reg <= MUL_STEPS'(b_reg); y_reg <= b_reg; end
                        OP_AB:   begin x_reg <= MUL_STEPS'(a_reg); y_reg <= b_reg; end
                        OP_F1:   begin x_reg <= MUL_STEPS'(s2_reg); y_reg <= a_reg; end
                        default: begin x_reg <= MUL_STEPS'(s1_reg); y_reg <= b_reg; end
                    endcase
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    acc_reg <= acc_step;
                    x_reg   <= {x_reg[MUL_STEPS-2:0], 1'b0};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end

                S_STORE:
                begin
                    state_reg <= S_LOAD;
                    case (op_reg)
                        OP_R1:
                        begin
                            s1_reg <= prod;
                            op_reg <= OP_R2;
                        end
                        OP_R2:
                        begin
                            s2_reg <= prod;
                            op_reg <= (bits_reg == '0) ? OP_F1 : OP_AA;
                        end
                        OP_AA:
                        begin
                            aa_reg <= prod;
                            op_reg <= OP_BB;
                        end
                        OP_BB:
                        begin
                            bb_reg <= prod;
                            op_reg <= OP_AB;
                        end
                        OP_AB:
                        begin
                            // F(2k+1) = a^2 + b^2, F(2k) = 2ab - b^2
                            a_reg     <= addmod(aa_reg, bb_reg, modulus_reg);
                            b_reg     <= submod(addmod(prod, prod, modulus_reg), bb_reg,
                                                modulus_reg);
                            state_reg <= S_STEP;
                        end
                        OP_F1:
                        begin
                            f1_reg <= prod;
                            op_reg <= OP_F2;
                        end
                        default:
                        begin
                            value_reg <= 31'(addmod(f1_reg, prod, modulus_reg));
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_STEP:
                begin
                    // index bit set: multiply by [[1,1],[1,0]]
                    if (n_reg[INDEX_BITS-1])
                    begin
                        a_reg <= addmod(a_reg, b_reg, modulus_reg);
                        b_reg <= a_reg;
                    end
                    n_reg     <= {n_reg[INDEX_BITS-2:0], 1'b0};
                    bits_reg  <= bits_reg - BCW'(1);
                    op_reg    <= (bits_reg == BCW'(1)) ? OP_F1 : OP_AA;
                    state_reg <= S_LOAD;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> (acc_reg < {2'b00, modulus_reg}))
        else $error("mulmod result not reduced");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (value < 31'(modulus_reg) || modulus_reg < MW'(2)))
        else $error("result not below modulus");

    // a modulus below two answers every cycle, so only full runs are one-shot
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && modulus_reg >= MW'(2)) |=> !done)
        else $error("result strobe held");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

endmodule : fibonacci_matrix_power_mod_core
`default_nettype wire
